### rtl/atl_pkg.sv
// Shared types, constants and byte-class functions for the assembler token lexer.
// No dependencies; every other file of the block uses this package.
`timescale 1ns / 1ps
package atl_pkg;

  localparam int LINE_W        = 16;
  localparam int LINE_BITS_DEF = 16;
  localparam int MAX_RES       = 4;
  localparam int CNT_W         = 3;
  localparam int FIFO_DEPTH    = 4;

  localparam logic [4:0] K_IDENT   = 5'd0;
  localparam logic [4:0] K_INT     = 5'd1;
  localparam logic [4:0] K_DIR     = 5'd2;
  localparam logic [4:0] K_CHAR    = 5'd3;
  localparam logic [4:0] K_STR     = 5'd4;
  localparam logic [4:0] K_PLUS    = 5'd5;
  localparam logic [4:0] K_MINUS   = 5'd6;
  localparam logic [4:0] K_STAR    = 5'd7;
  localparam logic [4:0] K_SLASH   = 5'd8;
  localparam logic [4:0] K_COMMA   = 5'd9;
  localparam logic [4:0] K_DOT     = 5'd10;
  localparam logic [4:0] K_COLON   = 5'd11;
  localparam logic [4:0] K_DOLLAR  = 5'd12;
  localparam logic [4:0] K_LPAREN  = 5'd13;
  localparam logic [4:0] K_RPAREN  = 5'd14;
  localparam logic [4:0] K_UNKNOWN = 5'd15;
  localparam logic [4:0] K_EOF     = 5'd16;

  localparam logic [3:0] M_IDLE    = 4'd0;
  localparam logic [3:0] M_IDENT   = 4'd1;
  localparam logic [3:0] M_INT     = 4'd2;
  localparam logic [3:0] M_DIR     = 4'd3;
  localparam logic [3:0] M_DOTWAIT = 4'd4;
  localparam logic [3:0] M_COMMENT = 4'd5;
  localparam logic [3:0] M_CHOPEN  = 4'd6;
  localparam logic [3:0] M_CHESC   = 4'd7;
  localparam logic [3:0] M_CHHEX   = 4'd8;
  localparam logic [3:0] M_CHCLOSE = 4'd9;
  localparam logic [3:0] M_STR     = 4'd10;
  localparam logic [3:0] M_STRESC  = 4'd11;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LC_N   = 8'h6E;
  localparam logic [7:0] CH_LC_R   = 8'h72;
  localparam logic [7:0] CH_LC_T   = 8'h74;
  localparam logic [7:0] CH_LC_X   = 8'h78;

  typedef struct packed {
    logic [4:0]        kind;
    logic              done;
    logic [7:0]        payload;
    logic [LINE_W-1:0] line;
  } tok_t;

  typedef struct packed {
    logic [CNT_W-1:0]        cnt;
    tok_t [MAX_RES-1:0]      res;
  } bundle_t;

  function automatic tok_t mk_tok(input logic [4:0] kind, input logic done,
                                  input logic [7:0] payload,
                                  input logic [LINE_W-1:0] line);
    tok_t t;
    t.kind    = kind;
    t.done    = done;
    t.payload = payload;
    t.line    = line;
    return t;
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return (b inside {[8'h61:8'h7A], [8'h41:8'h5A]});
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b inside {[8'h30:8'h39]});
  endfunction

  function automatic logic is_identpart(input logic [7:0] b);
    return (b == CH_UNDER) || is_alpha(b) || is_digit(b);
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b inside {[CH_TAB:CH_CR], CH_SPACE});
  endfunction

  // bit 4 set when b is a hex digit, low nibble is its value
  function automatic logic [4:0] hex_val(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (is_digit(b)) r = {1'b1, 4'(b - 8'h30)};
    else if (b inside {[8'h61:8'h66]}) r = {1'b1, 4'(b - 8'h57)};
    else if (b inside {[8'h41:8'h46]}) r = {1'b1, 4'(b - 8'h37)};
    return r;
  endfunction

  function automatic logic [7:0] unescape(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b == CH_LC_T) r = CH_TAB;
    else if (b == CH_LC_N) r = CH_LF;
    else if (b == CH_LC_R) r = CH_CR;
    return r;
  endfunction

  function automatic logic [4:0] punct_kind(input logic [7:0] b);
    logic [4:0] k;
    case (b)
      8'h2B:   k = K_PLUS;
      8'h2D:   k = K_MINUS;
      8'h2A:   k = K_STAR;
      8'h2F:   k = K_SLASH;
      8'h2C:   k = K_COMMA;
      8'h2E:   k = K_DOT;
      8'h3A:   k = K_COLON;
      8'h24:   k = K_DOLLAR;
      8'h28:   k = K_LPAREN;
      8'h29:   k = K_RPAREN;
      default: k = K_UNKNOWN;
    endcase
    return k;
  endfunction

endpackage

### rtl/atl_if.sv
// Stream interfaces of the assembler token lexer: source bytes in, token results out.
// Depends on atl_pkg for the line number width.
`timescale 1ns / 1ps
interface atl_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink (input valid, input text_byte, output ready);
endinterface

interface atl_tok_if;
  logic                      valid;
  logic                      ready;
  logic [4:0]                token_kind;
  logic                      is_complete;
  logic [7:0]                payload;
  logic [atl_pkg::LINE_W-1:0] line_number;
  logic                      run_end;

  modport source (output valid, output token_kind, output is_complete, output payload,
                  output line_number, output run_end, input ready);
  modport sink (input valid, input token_kind, input is_complete, input payload,
                input line_number, input run_end, output ready);
endinterface

### rtl/assembler_token_lexer_top.sv
// Top level of the assembler token lexer: front end, bundle queue and serializer.
// Depends on atl_pkg, atl_if, atl_front, atl_queue and atl_back.
//
// Usage: source text enters on text_in one byte per transfer; a zero byte ends the
// text, closes any open token, emits EOF (line 0) and returns the lexer to its
// start state with the line count at 1. Results leave on token_out: the text bytes
// of a token, then a completion result with the kind, char value and start line.
// run_end marks the last result caused by one input byte; bytes that cause no
// result (whitespace, comment text, literal openers) produce nothing.
// Throughput: one byte per cycle while each byte yields at most one result and the
// receiver does not stall; a byte yielding N results (N is at most 4) holds the
// output until all N have left, and the QUEUE_DEPTH bundle queue absorbs such
// bursts before text_in.ready drops. When the receiver stalls, results wait at the
// queue head and text_in keeps taking bytes until the queue is full. Synchronous
// reset empties the queue and restores the start state; no clearing pass is needed.
`timescale 1ns / 1ps
module assembler_token_lexer_top #(
  parameter int LINE_BITS   = atl_pkg::LINE_BITS_DEF,
  parameter int QUEUE_DEPTH = atl_pkg::FIFO_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  atl_byte_if.sink  text_in,
  atl_tok_if.source token_out
);
  import atl_pkg::*;

  logic    push, pop, q_empty, q_full;
  bundle_t wr_bundle, head_bundle;

  atl_front #(.LINE_BITS(LINE_BITS)) u_front (
    .clk     (clk),
    .rst     (rst),
    .text_in (text_in),
    .q_full  (q_full),
    .push    (push),
    .bundle  (wr_bundle)
  );

  atl_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (wr_bundle),
    .pop     (pop),
    .head    (head_bundle),
    .empty   (q_empty),
    .full    (q_full)
  );

  atl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head_bundle),
    .empty     (q_empty),
    .pop       (pop),
    .token_out (token_out)
  );
endmodule

### rtl/atl_front.sv
// Lexer front end: takes one byte per transfer, updates the lexer state and
// produces the bundle of up to four results for that byte. Depends on atl_pkg.
`timescale 1ns / 1ps
module atl_front #(
  parameter int LINE_BITS = atl_pkg::LINE_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  atl_byte_if.sink         text_in,
  input  logic             q_full,
  output logic             push,
  output atl_pkg::bundle_t bundle
);
  import atl_pkg::*;

  logic [3:0]           mode, mode_next;
  logic [LINE_BITS-1:0] line_count, line_next;
  logic [7:0]           acc, acc_next;
  logic [1:0]           hex_seen, hex_next;

  logic                 xfer;
  logic                 again;
  logic [7:0]           b;
  logic [4:0]           hv;
  logic [4:0]           k;
  logic [LINE_W-1:0]    ln;
  logic [CNT_W-1:0]     n;
  tok_t [MAX_RES-1:0]   res;

  assign text_in.ready = !q_full;
  assign xfer          = text_in.valid && text_in.ready;

  always_comb begin
    mode_next = mode;
    line_next = line_count;
    acc_next  = acc;
    hex_next  = hex_seen;
    again     = 1'b0;
    n         = '0;
    res       = '0;
    b         = text_in.text_byte;
    hv        = hex_val(b);
    ln        = LINE_W'(line_count);
    k         = (mode == M_IDENT) ? K_IDENT : K_DIR;

    case (mode)
      M_IDENT, M_DIR: begin
        if (b != CH_NUL && is_identpart(b)) begin
          res[n[1:0]] = mk_tok(k, 1'b0, b, ln); n = n + 1'b1;
        end else begin
          res[n[1:0]] = mk_tok(k, 1'b1, 8'd0, ln); n = n + 1'b1;
          again = 1'b1;
        end
      end
      M_INT: begin
        if (is_digit(b)) begin
          res[n[1:0]] = mk_tok(K_INT, 1'b0, b, ln); n = n + 1'b1;
        end else begin
          res[n[1:0]] = mk_tok(K_INT, 1'b1, 8'd0, ln); n = n + 1'b1;
          again = 1'b1;
        end
      end
      M_DOTWAIT: begin
        if (is_alpha(b)) begin
          res[n[1:0]] = mk_tok(K_DIR, 1'b0, CH_DOT, ln); n = n + 1'b1;
          res[n[1:0]] = mk_tok(K_DIR, 1'b0, b, ln); n = n + 1'b1;
          mode_next = M_DIR;
        end else begin
          res[n[1:0]] = mk_tok(K_DOT, 1'b0, CH_DOT, ln); n = n + 1'b1;
          res[n[1:0]] = mk_tok(K_DOT, 1'b1, 8'd0, ln); n = n + 1'b1;
          again = 1'b1;
        end
      end
      M_COMMENT: begin
        if (b == CH_NUL || b == CH_LF || b == CH_CR) again = 1'b1;
      end
      M_CHOPEN: begin
        if (b == CH_NUL) begin
          res[n[1:0]] = mk_tok(K_CHAR, 1'b1, 8'd0, ln); n = n + 1'b1;
          again = 1'b1;
        end else if (b == CH_QUOTE) begin
          res[n[1:0]] = mk_tok(K_CHAR, 1'b1, 8'd0, ln); n = n + 1'b1;
          mode_next = M_IDLE;
        end else if (b == CH_BSLASH) begin
          mode_next = M_CHESC;
        end else begin
          acc_next  = b;
          mode_next = M_CHCLOSE;
        end
      end
      M_CHESC: begin
        if (b == CH_NUL) begin
          res[n[1:0]] = mk_tok(K_CHAR, 1'b1, 8'd0, ln); n = n + 1'b1;
          again = 1'b1;
        end else if (b == CH_LC_X) begin
          acc_next  = 8'd0;
          hex_next  = 2'd0;
          mode_next = M_CHHEX;
        end else begin
          acc_next  = unescape(b);
          mode_next = M_CHCLOSE;
        end
      end
      M_CHHEX: begin
        if (b == CH_NUL) begin
          res[n[1:0]] = mk_tok(K_CHAR, 1'b1, acc, ln); n = n + 1'b1;
          again = 1'b1;
        end else if (b == CH_QUOTE) begin
          res[n[1:0]] = mk_tok(K_CHAR, 1'b1, acc, ln); n = n + 1'b1;
          mode_next = M_IDLE;
        end else if (hex_seen == 2'd0) begin
          if (hv[4]) begin
            acc_next = {4'd0, hv[3:0]};
            hex_next = 2'd1;
          end else begin
            hex_next = 2'd2;
          end
        end else begin
          if (hex_seen == 2'd1 && hv[4]) acc_next = {acc[3:0], hv[3:0]};
          mode_next = M_CHCLOSE;
        end
      end
      M_CHCLOSE: begin
        res[n[1:0]] = mk_tok(K_CHAR, 1'b1, acc, ln); n = n + 1'b1;
        if (b == CH_NUL) again = 1'b1;
        else mode_next = M_IDLE;
      end
      M_STR: begin
        if (b == CH_NUL) begin
          res[n[1:0]] = mk_tok(K_STR, 1'b1, 8'd0, ln); n = n + 1'b1;
          again = 1'b1;
        end else if (b == CH_DQUOTE) begin
          res[n[1:0]] = mk_tok(K_STR, 1'b1, 8'd0, ln); n = n + 1'b1;
          mode_next = M_IDLE;
        end else if (b == CH_BSLASH) begin
          mode_next = M_STRESC;
        end else begin
          res[n[1:0]] = mk_tok(K_STR, 1'b0, b, ln); n = n + 1'b1;
        end
      end
      M_STRESC: begin
        if (b == CH_NUL) begin
          res[n[1:0]] = mk_tok(K_STR, 1'b1, 8'd0, ln); n = n + 1'b1;
          again = 1'b1;
        end else begin
          res[n[1:0]] = mk_tok(K_STR, 1'b0, unescape(b), ln); n = n + 1'b1;
          mode_next = M_STR;
        end
      end
      default: again = 1'b1;
    endcase

    if (again) begin
      mode_next = M_IDLE;
      if (b == CH_NUL) begin
        res[n[1:0]] = mk_tok(K_EOF, 1'b1, 8'd0, '0); n = n + 1'b1;
        line_next = LINE_BITS'(1);
        acc_next  = 8'd0;
        hex_next  = 2'd0;
      end else if (is_space(b)) begin
        if (b == CH_LF && line_count != {LINE_BITS{1'b1}}) line_next = line_count + 1'b1;
      end else if (b == CH_UNDER || is_alpha(b)) begin
        res[n[1:0]] = mk_tok(K_IDENT, 1'b0, b, ln); n = n + 1'b1;
        mode_next = M_IDENT;
      end else if (is_digit(b)) begin
        res[n[1:0]] = mk_tok(K_INT, 1'b0, b, ln); n = n + 1'b1;
        mode_next = M_INT;
      end else if (b == CH_HASH) begin
        mode_next = M_COMMENT;
      end else if (b == CH_DOT) begin
        mode_next = M_DOTWAIT;
      end else if (b == CH_QUOTE) begin
        acc_next  = 8'd0;
        mode_next = M_CHOPEN;
      end else if (b == CH_DQUOTE) begin
        mode_next = M_STR;
      end else begin
        res[n[1:0]] = mk_tok(punct_kind(b), 1'b0, b, ln); n = n + 1'b1;
        res[n[1:0]] = mk_tok(punct_kind(b), 1'b1, 8'd0, ln); n = n + 1'b1;
      end
    end
  end

  assign push       = xfer && (n != '0);
  assign bundle.cnt = n;
  assign bundle.res = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= M_IDLE;
      line_count <= LINE_BITS'(1);
      acc        <= 8'd0;
      hex_seen   <= 2'd0;
    end else if (xfer) begin
      mode       <= mode_next;
      line_count <= line_next;
      acc        <= acc_next;
      hex_seen   <= hex_next;
    end
  end

  a_line_nonzero: assert property (@(posedge clk) disable iff (rst)
    line_count != '0) else $error("line counter reached zero");
  a_eof_clears: assert property (@(posedge clk) disable iff (rst)
    xfer && text_in.text_byte == CH_NUL |=> mode == M_IDLE && line_count == LINE_BITS'(1))
    else $error("zero byte did not restart the lexer");
  a_push_cnt: assert property (@(posedge clk) disable iff (rst)
    push |-> bundle.cnt <= CNT_W'(MAX_RES)) else $error("bundle count out of range");
endmodule

### rtl/atl_queue.sv
// Short queue of result bundles between the lexer front end and the output serializer.
// Depends on atl_pkg for the bundle type.
`timescale 1ns / 1ps
module atl_queue #(
  parameter int DEPTH = atl_pkg::FIFO_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  atl_pkg::bundle_t wr_data,
  input  logic             pop,
  output atl_pkg::bundle_t head,
  output logic             empty,
  output logic             full
);
  import atl_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  bundle_t         mem [DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;

  assign empty = (count == '0);
  assign full  = (count == CW'(DEPTH));
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty) else $error("pop from empty queue");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1) else $error("queue count lost a push");
endmodule

### rtl/atl_back.sv
// Output serializer: walks the results of the bundle at the queue head, one per
// transfer, and marks the last one of each input byte. Depends on atl_pkg.
`timescale 1ns / 1ps
module atl_back (
  input  logic             clk,
  input  logic             rst,
  input  atl_pkg::bundle_t head,
  input  logic             empty,
  output logic             pop,
  atl_tok_if.source        token_out
);
  import atl_pkg::*;

  logic [1:0]       idx;
  logic             last;
  logic             xfer;
  tok_t             cur;

  assign cur  = head.res[idx];
  assign last = (CNT_W'(idx) + 1'b1 == head.cnt);
  assign xfer = token_out.valid && token_out.ready;
  assign pop  = xfer && last;

  assign token_out.valid       = !empty;
  assign token_out.token_kind  = cur.kind;
  assign token_out.is_complete = cur.done;
  assign token_out.payload     = cur.payload;
  assign token_out.line_number = cur.line;
  assign token_out.run_end     = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (xfer) begin
      idx <= last ? '0 : idx + 1'b1;
    end
  end

  a_head_nonempty: assert property (@(posedge clk) disable iff (rst)
    token_out.valid |-> head.cnt != '0) else $error("empty bundle in queue");
  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    token_out.valid |-> CNT_W'(idx) < head.cnt) else $error("result index past bundle");
  a_idx_reset: assert property (@(posedge clk)
    rst |=> idx == '0) else $error("result index not cleared by reset");
endmodule
